// ----- hw/rtl/swc_pkg.sv -----
// shared types and constants of the stimulus window checker
package swc_pkg;

    localparam int TIME_W = 32;
    localparam int CNT_W  = 5;
    localparam int IDX_W  = 4;
    localparam int REG_W  = 2;

    localparam int OFS_VALUE   = IDX_W;
    localparam int OFS_QTIME   = IDX_W + TIME_W;
    localparam int OFS_TOTAL   = IDX_W + 2 * TIME_W;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 8;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    localparam logic [REG_W-1:0] REG_START    = 2'd0;
    localparam logic [REG_W-1:0] REG_DURATION = 2'd1;
    localparam logic [REG_W-1:0] REG_END      = 2'd2;
    localparam logic [REG_W-1:0] REG_COUNT    = 2'd3;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] pulse_duration;
        logic [TIME_W-1:0] end_limit;
        logic [CNT_W-1:0]  entry_count;
    } t_cfg;

endpackage

// ----- hw/rtl/swc_table.sv -----
// cycle length table: one write port, one registered read port
module swc_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [swc_pkg::TIME_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [swc_pkg::TIME_W-1:0] o_rdata
);
    import swc_pkg::*;

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/swc_div.sv -----
// 32-bit unsigned restoring divider, one quotient bit per cycle
module swc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [swc_pkg::TIME_W-1:0] i_dividend,
    input  logic [swc_pkg::TIME_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [swc_pkg::TIME_W-1:0] o_quot
);
    import swc_pkg::*;

    localparam int SW = $clog2(TIME_W);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_cnt;
    logic [TIME_W:0]   r_rem;
    logic [TIME_W-1:0] r_quot;
    logic [TIME_W-1:0] r_dvs;

    logic [TIME_W:0]   n_shift;
    logic              n_ge;
    logic [TIME_W:0]   n_rem;
    logic [TIME_W-1:0] n_quot;

    always_comb begin
        n_shift = {r_rem[TIME_W-1:0], r_quot[TIME_W-1]};
        n_ge    = n_shift >= {1'b0, r_dvs};
        n_rem   = n_ge ? (n_shift - {1'b0, r_dvs}) : n_shift;
        n_quot  = {r_quot[TIME_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == SW'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- hw/rtl/swc_core.sv -----
// query sequencer: table walk for list mode, divide and multiply for periodic mode
module swc_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  swc_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic [swc_pkg::IDX_W-1:0]  i_idx,
    input  logic [swc_pkg::TIME_W-1:0] i_value,
    input  logic [swc_pkg::TIME_W-1:0] i_qtime,
    input  logic [swc_pkg::TIME_W-1:0] i_total,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_active
);
    import swc_pkg::*;

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int SW = TIME_W + $clog2(MAX_ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRD  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_CHK  = 3'd4;
    localparam logic [2:0] S_LIST = 3'd5;
    localparam logic [2:0] S_LEND = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]        r_state;
    logic [TIME_W-1:0] r_q;
    logic [TIME_W-1:0] r_total;
    logic [CW-1:0]     r_n;
    logic [TIME_W-1:0] r_c;
    logic [TIME_W-1:0] r_qs;
    logic              r_fail;
    logic              r_usenp;
    logic [TIME_W-1:0] r_i;
    logic [TIME_W-1:0] r_prod;
    logic [SW-1:0]     r_lo;
    logic [SW-1:0]     r_sum;
    logic              r_hit;
    logic [CW-1:0]     r_step;
    logic              r_act;

    logic              accept;
    logic              tbl_we;
    logic              tbl_re;
    logic [AW-1:0]     tbl_raddr;
    logic [TIME_W-1:0] rd_data;
    logic [CW-1:0]     n_eff;
    logic [CW:0]       step_nx;
    logic [TIME_W-1:0] min_te;
    logic              div_start;
    logic              k_done;
    logic              np_done;
    logic [TIME_W-1:0] k_quot;
    logic [TIME_W-1:0] np_quot;
    logic [TIME_W-1:0] n_pulses;
    logic [TIME_W-1:0] n_last;
    logic [2*TIME_W-1:0] prod_full;
    logic [SW:0]       q_ext;
    logic [SW:0]       d_ext;
    logic              win;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    assign tbl_we = accept && (i_cmd == CMD_LOAD)
                    && (32'(i_idx) < 32'(MAX_ENTRIES));

    assign n_eff = (32'(i_cfg.entry_count) > 32'(MAX_ENTRIES))
                   ? CW'(MAX_ENTRIES) : CW'(i_cfg.entry_count);

    assign step_nx = {1'b0, r_step} + 1'b1;

    always_comb begin
        tbl_re    = 1'b0;
        tbl_raddr = '0;
        if (accept && (i_cmd == CMD_QUERY)) begin
            tbl_re = 1'b1;
        end else if ((r_state == S_LIST) && (step_nx < {1'b0, r_n})) begin
            tbl_re    = 1'b1;
            tbl_raddr = AW'(step_nx);
        end
    end

    swc_table #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (AW'(i_idx)),
        .i_wdata (i_value),
        .i_re    (tbl_re),
        .i_raddr (tbl_raddr),
        .o_rdata (rd_data)
    );

    assign min_te    = (r_total < i_cfg.end_limit) ? r_total : i_cfg.end_limit;
    assign div_start = (r_state == S_PRD);

    swc_div u_div_k (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_q - i_cfg.start_time),
        .i_divisor  (rd_data),
        .o_done     (k_done),
        .o_quot     (k_quot)
    );

    swc_div u_div_np (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (min_te),
        .i_divisor  (rd_data),
        .o_done     (np_done),
        .o_quot     (np_quot)
    );

    assign n_pulses  = r_usenp ? np_quot : TIME_W'(1);
    assign n_last    = n_pulses - 1'b1;
    assign prod_full = r_i * r_c;

    assign q_ext = (SW + 1)'(r_q);
    assign d_ext = (SW + 1)'(i_cfg.pulse_duration);
    assign win   = (q_ext >= {1'b0, r_lo}) && (q_ext <= ({1'b0, r_lo} + d_ext));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd == CMD_QUERY)) begin
                        if (n_eff == '0) begin
                            r_state <= S_DONE;
                        end else if (n_eff == CW'(1)) begin
                            r_state <= S_PRD;
                        end else begin
                            r_state <= S_LIST;
                        end
                    end
                end
                S_PRD: r_state <= S_DIV;
                S_DIV: begin
                    if (k_done && np_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_CHK;
                S_CHK: r_state <= S_DONE;
                S_LIST: begin
                    if (step_nx == {1'b0, r_n}) begin
                        r_state <= S_LEND;
                    end
                end
                S_LEND: r_state <= S_DONE;
                S_DONE: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_q     <= i_qtime;
                r_total <= i_total;
                r_n     <= n_eff;
                r_lo    <= SW'(i_cfg.start_time);
                r_sum   <= '0;
                r_hit   <= 1'b0;
                r_step  <= '0;
                r_act   <= 1'b0;
            end
            S_PRD: begin
                r_c     <= rd_data;
                r_qs    <= r_q - i_cfg.start_time;
                r_fail  <= (r_q < i_cfg.start_time) || (r_q > i_cfg.end_limit);
                r_usenp <= (rd_data != '0) && (r_total > rd_data);
            end
            S_DIV: begin
                // quotients are only final once both dividers are done
                if (k_done && np_done && (n_pulses == '0)) begin
                    r_fail <= 1'b1;
                end
                r_i <= (k_quot < n_last) ? k_quot : n_last;
            end
            S_MUL: r_prod <= prod_full[TIME_W-1:0];
            S_CHK: r_act <= !r_fail && ((r_qs - r_prod) <= i_cfg.pulse_duration);
            S_LIST: begin
                r_hit  <= r_hit | win;
                r_lo   <= r_lo + SW'(rd_data);
                r_sum  <= r_sum + SW'(rd_data);
                r_step <= r_step + 1'b1;
            end
            S_LEND: r_act <= r_hit && (q_ext <= ({1'b0, r_sum} + d_ext));
            default: ;
        endcase
    end

    assign o_valid  = (r_state == S_DONE);
    assign o_active = r_act;

endmodule

// ----- hw/rtl/stimulus_window_check.sv -----
// top level: stream ports, configuration registers and output register
//
// Stimulus window checker. A load item (tuser 1) writes a cycle length into one
// table entry; it gives no result. A query item (tuser 0) gives one result item
// telling whether query_time lies inside a pulse window. With entry_count 0 the
// answer is always inactive. With entry_count 1 (periodic mode) a query runs
// through the bit-serial 32-bit dividers that produce one quotient bit per
// cycle. With two or more entries (list mode) a query does one table read per
// entry. One query is worked on at a time; the next item is accepted while a
// finished result still waits in the output register. The table holds
// MAX_ENTRIES words and is not cleared by reset; entries must be loaded before
// a query uses them.
module stimulus_window_check #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] entry_index, [35:4] entry_value, [67:36] query_time,
    // [99:68] run_span, [103:100] zero
    input  logic [swc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] active, [7:1] zero
    output logic [swc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [swc_pkg::REG_W-1:0]       i_cfg_addr,
    input  logic [swc_pkg::TIME_W-1:0]      i_cfg_wdata
);
    import swc_pkg::*;

    t_cfg r_cfg;
    logic r_out_valid;
    logic r_out_active;

    logic core_valid;
    logic core_ready;
    logic core_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_time     <= '0;
            r_cfg.pulse_duration <= '0;
            r_cfg.end_limit      <= '1;
            r_cfg.entry_count    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_START:    r_cfg.start_time     <= i_cfg_wdata;
                REG_DURATION: r_cfg.pulse_duration <= i_cfg_wdata;
                REG_END:      r_cfg.end_limit      <= i_cfg_wdata;
                REG_COUNT:    r_cfg.entry_count    <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    swc_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_cmd    (s_axis_tuser),
        .i_idx    (s_axis_tdata[IDX_W-1:0]),
        .i_value  (s_axis_tdata[OFS_VALUE +: TIME_W]),
        .i_qtime  (s_axis_tdata[OFS_QTIME +: TIME_W]),
        .i_total  (s_axis_tdata[OFS_TOTAL +: TIME_W]),
        .o_valid  (core_valid),
        .i_ready  (core_ready),
        .o_active (core_active)
    );

    assign core_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_ready) begin
            r_out_valid <= core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (core_ready && core_valid) begin
            r_out_active <= core_active;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - 1)'(0), r_out_active};

endmodule

// ----- hw/rtl/swc_checker.sv -----
// port-level checks of the stimulus window checker, bound to the top level
module swc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [swc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import swc_pkg::*;

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("result padding bits not zero");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a query occupies the block
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY)
        |=> !s_axis_tready)
        else $error("ready stayed high after a query item");

    // a load keeps the input ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_LOAD)
        |=> s_axis_tready)
        else $error("ready dropped after a load item");

endmodule

bind stimulus_window_check swc_checker u_swc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/stimulus_window_check_test.sv -----
// testbench of the stimulus window checker: stream driver, result monitor and pulse predictor
module stimulus_window_check_test;
    import swc_pkg::*;

    localparam int ENTRIES     = 16;
    localparam int CYCLE_LIMIT = 800_000;
    localparam int SETTLE      = 60;
    localparam int IDLE_PCT    = 26;
    localparam int HOLD_CYCLES = 600;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 150;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] value;
        logic [TIME_W-1:0] qtime;
        logic [TIME_W-1:0] total;
    } t_stim_item;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [REG_W-1:0]       i_cfg_addr = '0;
    logic [TIME_W-1:0]      i_cfg_wdata = '0;

    t_stim_item        pending_items[$];
    bit                expected_active[$];
    t_cfg              cfg_now;
    logic [TIME_W-1:0] cycle_len [ENTRIES];
    logic [TIME_W-1:0] plan_len [ENTRIES];

    bit steady = 1'b0;
    int stall_reqs = 0;
    int stall_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int errors = 0;
    int loads_sent = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int settings_run = 0;

    stimulus_window_check #(
        .MAX_ENTRIES(ENTRIES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit pulse_window_active(input logic [TIME_W-1:0] qt,
                                               input logic [TIME_W-1:0] tot);
        logic [63:0] q, s, d, e, c, n, k, i, sum, stop;
        int unsigned cnt;
        q = 64'(qt);
        s = 64'(cfg_now.start_time);
        d = 64'(cfg_now.pulse_duration);
        e = 64'(cfg_now.end_limit);
        cnt = (32'(cfg_now.entry_count) > ENTRIES) ? ENTRIES : 32'(cfg_now.entry_count);
        if (cnt == 0)
            return 1'b0;
        if (cnt == 1) begin
            c = 64'(cycle_len[0]);
            n = 1;
            if (c != 0 && 64'(tot) > c)
                n = ((64'(tot) < e) ? 64'(tot) : e) / c;
            if (n == 0 || q < s || q > e)
                return 1'b0;
            if (c == 0)
                return q <= s + d;
            k = (q - s) / c;
            i = (k < n - 1) ? k : n - 1;
            return (q - s) - i * c <= d;
        end
        sum = 0;
        for (int j = 0; j < cnt; j++)
            sum += 64'(cycle_len[j]);
        stop = sum + d;
        sum = 0;
        for (int j = 0; j < cnt; j++) begin
            if (q >= s + sum && q <= s + sum + d && q <= stop)
                return 1'b1;
            sum += 64'(cycle_len[j]);
        end
        return 1'b0;
    endfunction

    task automatic report_error(input string what, input int want_v, input int got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch at cycle %0d: %s, expected %0d got %0d",
                     cycle_count, what, want_v, got_v);
    endtask

    // driver
    always @(posedge i_clk) begin
        t_stim_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == CMD_LOAD) begin
                    cycle_len[s_axis_tdata[IDX_W-1:0]] = s_axis_tdata[OFS_VALUE +: TIME_W];
                    loads_sent++;
                end else begin
                    expected_active.push_back(pulse_window_active(
                        s_axis_tdata[OFS_QTIME +: TIME_W], s_axis_tdata[OFS_TOTAL +: TIME_W]));
                    queries_sent++;
                end
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_items.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= nxt.cmd;
                    s_axis_tdata  <= {{(IN_TDATA_W - IDX_W - 3 * TIME_W){1'b0}},
                                      nxt.total, nxt.qtime, nxt.value, nxt.idx};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (stall_seen != stall_reqs) begin
            stall_seen <= stall_reqs;
            hold_left  <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        bit want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL stimulus_window_check");
            $finish;
        end else if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_active.size() == 0) begin
                    report_error("result with nothing pending", -1, m_axis_tdata[0]);
                end else begin
                    want = expected_active.pop_front();
                    if (m_axis_tdata[0] !== want)
                        report_error("active", want, m_axis_tdata[0]);
                end
            end
            m_axis_tready <= (hold_left == 0) && (steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_load(input int idx, input logic [TIME_W-1:0] val);
        t_stim_item it;
        it.cmd   = CMD_LOAD;
        it.idx   = IDX_W'(idx);
        it.value = val;
        it.qtime = $urandom;
        it.total = $urandom;
        pending_items.push_back(it);
        plan_len[idx] = val;
    endtask

    task automatic push_query(input logic [TIME_W-1:0] qt, input logic [TIME_W-1:0] tot);
        t_stim_item it;
        it.cmd   = CMD_QUERY;
        it.idx   = IDX_W'($urandom);
        it.value = $urandom;
        it.qtime = qt;
        it.total = tot;
        pending_items.push_back(it);
    endtask

    task automatic wait_idle;
        do
            @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_active.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] du,
                                input logic [TIME_W-1:0] en, input logic [CNT_W-1:0] cnt);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_START;
        i_cfg_wdata <= st;
        @(posedge i_clk);
        i_cfg_addr  <= REG_DURATION;
        i_cfg_wdata <= du;
        @(posedge i_clk);
        i_cfg_addr  <= REG_END;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_addr  <= REG_COUNT;
        i_cfg_wdata <= TIME_W'(cnt);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_now.start_time     = st;
        cfg_now.pulse_duration = du;
        cfg_now.end_limit      = en;
        cfg_now.entry_count    = cnt;
        settings_run++;
        @(negedge i_clk);
    endtask

    function automatic logic [TIME_W-1:0] pick_tick();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(0, 255);
            3: return $urandom_range(0, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_len();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return $urandom;
            2: return '1;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [TIME_W-1:0] st, du, en, qt, tot, dclip;
        logic [CNT_W-1:0]  cnt;
        logic [63:0]       base;
        int unsigned       mode, eff, k, j, r;
        mode = $urandom_range(0, 9);
        if (mode == 0)
            cnt = '0;
        else if (mode <= 5)
            cnt = CNT_W'(1);
        else if (mode <= 8)
            cnt = CNT_W'($urandom_range(2, ENTRIES));
        else
            cnt = CNT_W'($urandom_range(ENTRIES + 1, 31));
        st = pick_tick();
        du = ($urandom_range(0, 3) == 0) ? pick_tick() : $urandom_range(0, 64);
        en = ($urandom_range(0, 3) == 0) ? pick_tick() : st + $urandom_range(0, 100000);
        write_config(st, du, en, cnt);
        eff = (cnt > ENTRIES) ? ENTRIES : 32'(cnt);
        dclip = (du > 100) ? 100 : du;
        if (eff == 1)
            push_load(0, pick_len());
        for (int i = 0; i < eff && eff > 1; i++)
            if ($urandom_range(0, 1) == 1)
                push_load(i, pick_len());
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                push_load($urandom_range(0, ENTRIES - 1), pick_len());
            end else if (r < 75 && eff > 0) begin
                tot = $urandom;
                if (eff == 1) begin
                    k = $urandom_range(0, 30);
                    base = 64'(st) + 64'(k) * 64'(plan_len[0]);
                    case ($urandom_range(0, 3))
                        0: tot = $urandom;
                        1: tot = plan_len[0];
                        default: tot = 32'(64'(k + $urandom_range(0, 3)) * 64'(plan_len[0])
                                           + 64'($urandom_range(0, 1)));
                    endcase
                end else begin
                    j = $urandom_range(0, eff - 1);
                    base = 64'(st);
                    for (int m = 0; m < j; m++)
                        base += 64'(plan_len[m]);
                end
                if ($urandom_range(0, 7) == 0)
                    qt = 32'(base - 1);
                else
                    qt = 32'(base + 64'($urandom_range(0, dclip + 2)));
                push_query(qt, tot);
            end else begin
                push_query(($urandom_range(0, 3) == 0) ? pick_tick() : $urandom, pick_tick());
            end
        end
    endtask

    initial begin
        cfg_now.start_time     = '0;
        cfg_now.pulse_duration = '0;
        cfg_now.end_limit      = '1;
        cfg_now.entry_count    = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            cycle_len[i] = '0;
            plan_len[i]  = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings, no entries in use: fill the whole table
        for (int i = 0; i < ENTRIES; i++)
            push_load(i, (i == ENTRIES - 1) ? 32'hFFFF_FFFF : (i == 3) ? 32'd0 : 10 * (i + 1));
        push_query(32'd0, 32'd0);
        push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        wait_idle();

        // periodic mode: window edges, end limit, total bounds, zero cycle, no pulses
        write_config(32'd100, 32'd5, 32'd1000, 5'd1);
        push_load(0, 32'd50);
        push_query(32'd99, 32'hFFFF_FFFF);
        push_query(32'd100, 32'hFFFF_FFFF);
        push_query(32'd105, 32'hFFFF_FFFF);
        push_query(32'd106, 32'hFFFF_FFFF);
        push_query(32'd955, 32'hFFFF_FFFF);
        push_query(32'd1050, 32'hFFFF_FFFF);
        push_query(32'd150, 32'd0);
        push_query(32'd150, 32'd50);
        push_load(0, 32'd0);
        push_query(32'd103, 32'd7);
        push_load(0, 32'd2000);
        push_query(32'd100, 32'd3000);
        wait_idle();

        write_config(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1);
        push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_query(32'd0, 32'd1);
        wait_idle();

        // list mode
        write_config(32'd20, 32'd3, 32'd0, 5'd3);
        push_load(0, 32'd10);
        push_query(32'd20, 32'd0);
        push_query(32'd24, 32'd0);
        push_query(32'd53, 32'd0);
        push_query(32'd54, 32'd0);
        wait_idle();

        // entry count beyond the table saturates
        write_config(32'd0, 32'd0, 32'd0, 5'd31);
        push_query(32'd0, 32'd0);
        push_query(32'd10, 32'd0);
        push_query(32'hFFFF_FFFF, 32'd0);
        wait_idle();

        write_config(32'd5, 32'd2, 32'hFFFF_FFFF, 5'd17);
        push_query(32'd5, 32'd0);
        push_query(32'd15, 32'd0);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            steady = (p == 3);
            random_phase(PHASE_ITEMS);
            if (p == 6)
                stall_reqs++;
            wait_idle();
        end
        steady = 1'b0;

        $display("covered %0d loads and %0d queries over %0d register settings",
                 loads_sent, queries_sent, settings_run);
        $display("%0d results checked, %0d errors, %0d cycles",
                 results_seen, errors, cycle_count);
        if (errors == 0 && expected_active.size() == 0)
            $display("PASS stimulus_window_check");
        else
            $display("FAIL stimulus_window_check");
        $finish;
    end

endmodule
